>>> src/sixfk_pkg.sv
// shared constants, types and rounding helper for the six-axis forward kinematics core
package sixfk_pkg;

   localparam int JOINT_COUNT      = 6;
   localparam int ANGLE_BITS       = 16;
   localparam int ANGLE_FIELD_BITS = 16;
   localparam int REG_COUNT        = 6;
   localparam int REG_BITS         = 18;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int PHASE_BITS       = 32;

   localparam int CORDIC_STEPS     = 24;
   localparam int STEPS_PER_STAGE  = 2;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / STEPS_PER_STAGE;
   localparam int CORDIC_BITS      = 33;

   localparam int Q_BITS           = 32;
   localparam int Q_FRAC           = 30;
   localparam int PROD_BITS        = 2 * Q_BITS;
   localparam int SUM_BITS         = PROD_BITS + 2;
   localparam int LEN_PROD_BITS    = REG_BITS + Q_BITS;
   localparam int POS_BITS_INT     = 40;
   localparam int POS_EXTRA        = 8;

   localparam int ROT_BITS         = 16;
   localparam int ROT_SHIFT        = 16;
   localparam int POS_BITS         = 18;
   localparam int REQ_DATA_BITS    = 96;
   localparam int RSP_DATA_BITS    = 200;
   localparam int ROT_FIELDS       = 9;

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [Q_BITS-1:0]      Q_ONE     = 32'sd1073741824;

   localparam logic signed [SUM_BITS-1:0] ROT_MAX = 66'sd16384;
   localparam logic signed [SUM_BITS-1:0] ROT_MIN = -66'sd16384;
   localparam logic signed [SUM_BITS-1:0] POS_MAX = 66'sd131071;
   localparam logic signed [SUM_BITS-1:0] POS_MIN = -66'sd131072;

   localparam logic [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SHOULDER_HEIGHT  = 3'd0,
      REG_UPPER_ARM_LENGTH = 3'd1,
      REG_FOREARM_LENGTH   = 3'd2,
      REG_WRIST_ONE_OFFSET = 3'd3,
      REG_WRIST_TWO_OFFSET = 3'd4,
      REG_FLANGE_OFFSET    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      TWIST_ZERO  = 2'd0,
      TWIST_PLUS  = 2'd1,
      TWIST_MINUS = 2'd2
   } twist_type;

   localparam twist_type JOINT_TWIST [JOINT_COUNT] = '{
      TWIST_PLUS, TWIST_ZERO, TWIST_ZERO, TWIST_PLUS, TWIST_MINUS, TWIST_ZERO
   };

   localparam int NO_REG = -1;
   localparam int LEN_REG [JOINT_COUNT] = '{
      NO_REG, int'(REG_UPPER_ARM_LENGTH), int'(REG_FOREARM_LENGTH), NO_REG, NO_REG, NO_REG
   };
   localparam int OFF_REG [JOINT_COUNT] = '{
      int'(REG_SHOULDER_HEIGHT), NO_REG, NO_REG, int'(REG_WRIST_ONE_OFFSET),
      int'(REG_WRIST_TWO_OFFSET), int'(REG_FLANGE_OFFSET)
   };

   localparam logic signed [REG_BITS-1:0] REG_RESET [REG_COUNT] = '{
      18'sd5843, -18'sd27853, -18'sd25706, 18'sd7153, 18'sd6203, 18'sd5394
   };

   // round half up, then arithmetic shift
   function automatic logic signed [SUM_BITS-1:0] round_shift(
      input logic signed [SUM_BITS-1:0] v, input int s);
      round_shift = (v + (66'sd1 <<< (s - 1))) >>> s;
   endfunction

endpackage

>>> src/six_axis_forward_kinematics_core.sv
// six-axis forward kinematics: cordic sine/cosine pipeline followed by a pipelined link chain
//
// Input channel req_*: one transaction carries six 16-bit joint angles (binary angle,
// one full turn is 2^ANGLE_BITS). Result channel rsp_*: one transaction carries the
// end-effector rotation (nine entries, 16384 is one) and position (three 18-bit values,
// same scale as the length registers), rounded and saturated.
// Configuration channel csr_*: writes one of the six link length/offset registers by
// index; csr_ready is always high, writes to unused indexes are dropped. Write only
// while no transaction is in flight.
// From input acceptance to rsp_tvalid a transaction passes one capture stage, twelve
// cordic stages of two rotation steps each, one sign-fix stage, four stages per joint
// for six joints (rotate products, sum/round, translation products, position sum), one
// rounding stage and the output register.
// Throughput is one transaction per cycle while req_tready is high; each 32x32 multiply
// sits alone between registers and sets the stage depth.
// When rsp_tready is low the output register holds and a one-entry skid buffer takes
// the next result; only when that too is full does the pipeline stall and req_tready
// fall. Nothing is dropped or repeated across a stall.
// Reset is synchronous: all valid bits clear and the length registers return to their
// default link geometry.
module six_axis_forward_kinematics_core #(
   parameter int ANGLE_BITS = sixfk_pkg::ANGLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // angle_base, angle_shoulder, angle_elbow, angle_wrist_one, angle_wrist_two,
   // angle_wrist_three (16 bits each, from bit 0)
   input  logic [sixfk_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rot_row0_col0 .. rot_row2_col2 (16 bits each, row-major from bit 0),
   // pos_x, pos_y, pos_z (18 bits each), two zero pad bits
   output logic [sixfk_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sixfk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sixfk_pkg::REG_BITS-1:0]       csr_data
);

   localparam int JC  = sixfk_pkg::JOINT_COUNT;
   localparam int NC  = sixfk_pkg::CORDIC_STAGES;
   localparam int CW  = sixfk_pkg::CORDIC_BITS;
   localparam int QW  = sixfk_pkg::Q_BITS;
   localparam int PRW = sixfk_pkg::PROD_BITS;
   localparam int SW  = sixfk_pkg::SUM_BITS;
   localparam int AW  = sixfk_pkg::LEN_PROD_BITS;
   localparam int PW  = sixfk_pkg::POS_BITS_INT;
   localparam int RB  = sixfk_pkg::REG_BITS;
   localparam int FB  = sixfk_pkg::ANGLE_FIELD_BITS;
   localparam int PHB = sixfk_pkg::PHASE_BITS;
   localparam int DW  = sixfk_pkg::RSP_DATA_BITS;

   // configuration registers
   logic signed [RB-1:0] cfg_ff [sixfk_pkg::REG_COUNT];
   logic signed [RB-1:0] cfg_in [sixfk_pkg::REG_COUNT];
   logic signed [RB-1:0] link_a [JC];
   logic signed [RB-1:0] link_d [JC];

   logic en;

   // cordic stages
   logic signed [CW-1:0] cx_ff [NC+1][JC];
   logic signed [CW-1:0] cx_in [NC+1][JC];
   logic signed [CW-1:0] cy_ff [NC+1][JC];
   logic signed [CW-1:0] cy_in [NC+1][JC];
   logic signed [CW-1:0] cz_ff [NC+1][JC];
   logic signed [CW-1:0] cz_in [NC+1][JC];
   logic                 cn_ff [NC+1][JC];
   logic                 cn_in [NC+1][JC];
   logic [NC:0]          vc_ff;
   logic [NC:0]          vc_in;

   // sign-fixed sine/cosine
   logic signed [QW-1:0] cos_ff [JC];
   logic signed [QW-1:0] cos_in [JC];
   logic signed [QW-1:0] sin_ff [JC];
   logic signed [QW-1:0] sin_in [JC];
   logic                 vf_ff;
   logic                 vf_in;

   // joint stage 1: rotation products
   logic signed [PRW-1:0] pc0_ff [JC][3];
   logic signed [PRW-1:0] pc0_in [JC][3];
   logic signed [PRW-1:0] ps0_ff [JC][3];
   logic signed [PRW-1:0] ps0_in [JC][3];
   logic signed [PRW-1:0] pc1_ff [JC][3];
   logic signed [PRW-1:0] pc1_in [JC][3];
   logic signed [PRW-1:0] ps1_ff [JC][3];
   logic signed [PRW-1:0] ps1_in [JC][3];
   logic signed [AW-1:0]  pac_ff [JC];
   logic signed [AW-1:0]  pac_in [JC];
   logic signed [AW-1:0]  pas_ff [JC];
   logic signed [AW-1:0]  pas_in [JC];
   logic signed [QW-1:0]  r1_ff [JC][3][3];
   logic signed [QW-1:0]  r1_in [JC][3][3];
   logic signed [PW-1:0]  p1_ff [JC][3];
   logic signed [PW-1:0]  p1_in [JC][3];
   logic signed [QW-1:0]  cos1_ff [JC][JC];
   logic signed [QW-1:0]  cos1_in [JC][JC];
   logic signed [QW-1:0]  sin1_ff [JC][JC];
   logic signed [QW-1:0]  sin1_in [JC][JC];

   // joint stage 2: new rotation, translation
   logic signed [QW-1:0]  rn2_ff [JC][3][3];
   logic signed [QW-1:0]  rn2_in [JC][3][3];
   logic signed [QW-1:0]  ro2_ff [JC][3][3];
   logic signed [QW-1:0]  ro2_in [JC][3][3];
   logic signed [QW-1:0]  t2_ff [JC][3];
   logic signed [QW-1:0]  t2_in [JC][3];
   logic signed [PW-1:0]  p2_ff [JC][3];
   logic signed [PW-1:0]  p2_in [JC][3];
   logic signed [QW-1:0]  cos2_ff [JC][JC];
   logic signed [QW-1:0]  cos2_in [JC][JC];
   logic signed [QW-1:0]  sin2_ff [JC][JC];
   logic signed [QW-1:0]  sin2_in [JC][JC];

   // joint stage 3: translation products
   logic signed [PRW-1:0] rt3_ff [JC][3][3];
   logic signed [PRW-1:0] rt3_in [JC][3][3];
   logic signed [QW-1:0]  rn3_ff [JC][3][3];
   logic signed [QW-1:0]  rn3_in [JC][3][3];
   logic signed [PW-1:0]  p3_ff [JC][3];
   logic signed [PW-1:0]  p3_in [JC][3];
   logic signed [QW-1:0]  cos3_ff [JC][JC];
   logic signed [QW-1:0]  cos3_in [JC][JC];
   logic signed [QW-1:0]  sin3_ff [JC][JC];
   logic signed [QW-1:0]  sin3_in [JC][JC];

   // joint stage 4: accumulated pose
   logic signed [QW-1:0]  r4_ff [JC][3][3];
   logic signed [QW-1:0]  r4_in [JC][3][3];
   logic signed [PW-1:0]  p4_ff [JC][3];
   logic signed [PW-1:0]  p4_in [JC][3];
   logic signed [QW-1:0]  cos4_ff [JC][JC];
   logic signed [QW-1:0]  cos4_in [JC][JC];
   logic signed [QW-1:0]  sin4_ff [JC][JC];
   logic signed [QW-1:0]  sin4_in [JC][JC];

   logic [JC-1:0] v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;

   // rounding stage, output register and skid buffer
   logic [DW-1:0] last_d_ff, last_d_in;
   logic          last_v_ff, last_v_in;
   logic [DW-1:0] out_d_ff, out_d_in;
   logic          out_v_ff, out_v_in;
   logic [DW-1:0] skid_d_ff, skid_d_in;
   logic          skid_v_ff, skid_v_in;
   logic          push;

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && (csr_index <= sixfk_pkg::REG_FLANGE_OFFSET)) begin
         cfg_in[csr_index] = csr_data;
      end
   end

   for (genvar g = 0; g < JC; g++) begin : g_link
      if (sixfk_pkg::LEN_REG[g] == sixfk_pkg::NO_REG) begin : g_no_a
         assign link_a[g] = '0;
      end else begin : g_a
         assign link_a[g] = cfg_ff[sixfk_pkg::LEN_REG[g]];
      end
      if (sixfk_pkg::OFF_REG[g] == sixfk_pkg::NO_REG) begin : g_no_d
         assign link_d[g] = '0;
      end else begin : g_d
         assign link_d[g] = cfg_ff[sixfk_pkg::OFF_REG[g]];
      end
   end

   // cordic: capture, then two rotation steps per stage
   always_comb begin
      logic signed [PHB-1:0] ext;
      logic [PHB-1:0]        phase;
      logic signed [CW-1:0]  x, y, z, dx, dy, atan;
      int                    i;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      cn_in = cn_ff;
      for (int j = 0; j < JC; j++) begin
         ext   = PHB'(signed'(req_tdata[FB*j +: FB]));
         phase = {ext[ANGLE_BITS-1:0], {(PHB-ANGLE_BITS){1'b0}}};
         // second and third quadrant: turn by half a turn, negate later
         cn_in[0][j] = phase[PHB-1] ^ phase[PHB-2];
         if (cn_in[0][j]) begin
            phase[PHB-1] = ~phase[PHB-1];
         end
         cx_in[0][j] = sixfk_pkg::CORDIC_X0;
         cy_in[0][j] = '0;
         cz_in[0][j] = CW'(signed'(phase));
      end
      for (int k = 1; k <= NC; k++) begin
         for (int j = 0; j < JC; j++) begin
            x = cx_ff[k-1][j];
            y = cy_ff[k-1][j];
            z = cz_ff[k-1][j];
            for (int m = 0; m < sixfk_pkg::STEPS_PER_STAGE; m++) begin
               i    = (k - 1) * sixfk_pkg::STEPS_PER_STAGE + m;
               dx   = y >>> i;
               dy   = x >>> i;
               atan = CW'(sixfk_pkg::CORDIC_ATAN[i]);
               if (z >= 0) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - atan;
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + atan;
               end
            end
            cx_in[k][j] = x;
            cy_in[k][j] = y;
            cz_in[k][j] = z;
            cn_in[k][j] = cn_ff[k-1][j];
         end
      end
      vc_in = {vc_ff[NC-1:0], req_tvalid};
   end

   always_comb begin
      logic signed [CW-1:0] xc, ys;
      for (int j = 0; j < JC; j++) begin
         xc = cn_ff[NC][j] ? -cx_ff[NC][j] : cx_ff[NC][j];
         ys = cn_ff[NC][j] ? -cy_ff[NC][j] : cy_ff[NC][j];
         cos_in[j] = xc[QW-1:0];
         sin_in[j] = ys[QW-1:0];
      end
      vf_in = vc_ff[NC];
   end

   // link chain, four stages per joint
   always_comb begin
      logic signed [QW-1:0] sr [3][3];
      logic signed [PW-1:0] sp [3];
      logic signed [QW-1:0] scos [JC];
      logic signed [QW-1:0] ssin [JC];
      logic                 sv;
      logic signed [SW-1:0] su, sw, swn, sacc, st;
      logic signed [QW-1:0] dext;
      for (int g = 0; g < JC; g++) begin
         if (g == 0) begin
            for (int i = 0; i < 3; i++) begin
               for (int k = 0; k < 3; k++) begin
                  sr[i][k] = (i == k) ? sixfk_pkg::Q_ONE : '0;
               end
               sp[i] = '0;
            end
            scos = cos_ff;
            ssin = sin_ff;
            sv   = vf_ff;
         end else begin
            sr   = r4_ff[g-1];
            sp   = p4_ff[g-1];
            scos = cos4_ff[g-1];
            ssin = sin4_ff[g-1];
            sv   = v4_ff[g-1];
         end

         // stage 1
         for (int i = 0; i < 3; i++) begin
            pc0_in[g][i] = sr[i][0] * scos[g];
            ps0_in[g][i] = sr[i][0] * ssin[g];
            pc1_in[g][i] = sr[i][1] * scos[g];
            ps1_in[g][i] = sr[i][1] * ssin[g];
         end
         pac_in[g]  = link_a[g] * scos[g];
         pas_in[g]  = link_a[g] * ssin[g];
         r1_in[g]   = sr;
         p1_in[g]   = sp;
         cos1_in[g] = scos;
         sin1_in[g] = ssin;
         v1_in[g]   = sv;

         // stage 2
         for (int i = 0; i < 3; i++) begin
            su  = sixfk_pkg::round_shift(SW'(pc0_ff[g][i]) + SW'(ps1_ff[g][i]),
                                         sixfk_pkg::Q_FRAC);
            sacc = SW'(pc1_ff[g][i]) - SW'(ps0_ff[g][i]);
            sw  = sixfk_pkg::round_shift(sacc, sixfk_pkg::Q_FRAC);
            swn = sixfk_pkg::round_shift(-sacc, sixfk_pkg::Q_FRAC);
            rn2_in[g][i][0] = su[QW-1:0];
            unique case (sixfk_pkg::JOINT_TWIST[g])
               sixfk_pkg::TWIST_PLUS: begin
                  rn2_in[g][i][1] = r1_ff[g][i][2];
                  rn2_in[g][i][2] = swn[QW-1:0];
               end
               sixfk_pkg::TWIST_MINUS: begin
                  rn2_in[g][i][1] = -r1_ff[g][i][2];
                  rn2_in[g][i][2] = sw[QW-1:0];
               end
               default: begin
                  rn2_in[g][i][1] = sw[QW-1:0];
                  rn2_in[g][i][2] = r1_ff[g][i][2];
               end
            endcase
         end
         st = sixfk_pkg::round_shift(SW'(pac_ff[g]), sixfk_pkg::Q_FRAC - sixfk_pkg::POS_EXTRA);
         t2_in[g][0] = st[QW-1:0];
         st = sixfk_pkg::round_shift(SW'(pas_ff[g]), sixfk_pkg::Q_FRAC - sixfk_pkg::POS_EXTRA);
         t2_in[g][1] = st[QW-1:0];
         dext        = QW'(link_d[g]);
         t2_in[g][2] = dext <<< sixfk_pkg::POS_EXTRA;
         ro2_in[g]   = r1_ff[g];
         p2_in[g]    = p1_ff[g];
         cos2_in[g]  = cos1_ff[g];
         sin2_in[g]  = sin1_ff[g];
         v2_in[g]    = v1_ff[g];

         // stage 3
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               rt3_in[g][i][k] = ro2_ff[g][i][k] * t2_ff[g][k];
            end
         end
         rn3_in[g]  = rn2_ff[g];
         p3_in[g]   = p2_ff[g];
         cos3_in[g] = cos2_ff[g];
         sin3_in[g] = sin2_ff[g];
         v3_in[g]   = v2_ff[g];

         // stage 4
         for (int i = 0; i < 3; i++) begin
            sacc = sixfk_pkg::round_shift(SW'(rt3_ff[g][i][0]) + SW'(rt3_ff[g][i][1])
                                          + SW'(rt3_ff[g][i][2]), sixfk_pkg::Q_FRAC);
            p4_in[g][i] = p3_ff[g][i] + sacc[PW-1:0];
         end
         r4_in[g]   = rn3_ff[g];
         cos4_in[g] = cos3_ff[g];
         sin4_in[g] = sin3_ff[g];
         v4_in[g]   = v3_ff[g];
      end
   end

   // final rounding and saturation
   always_comb begin
      logic signed [SW-1:0] v;
      last_d_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            v = sixfk_pkg::round_shift(SW'(r4_ff[JC-1][i][k]), sixfk_pkg::ROT_SHIFT);
            if (v > sixfk_pkg::ROT_MAX) begin
               v = sixfk_pkg::ROT_MAX;
            end else if (v < sixfk_pkg::ROT_MIN) begin
               v = sixfk_pkg::ROT_MIN;
            end
            last_d_in[sixfk_pkg::ROT_BITS*(3*i+k) +: sixfk_pkg::ROT_BITS] =
               v[sixfk_pkg::ROT_BITS-1:0];
         end
      end
      for (int i = 0; i < 3; i++) begin
         v = sixfk_pkg::round_shift(SW'(p4_ff[JC-1][i]), sixfk_pkg::POS_EXTRA);
         if (v > sixfk_pkg::POS_MAX) begin
            v = sixfk_pkg::POS_MAX;
         end else if (v < sixfk_pkg::POS_MIN) begin
            v = sixfk_pkg::POS_MIN;
         end
         last_d_in[sixfk_pkg::ROT_BITS*sixfk_pkg::ROT_FIELDS + sixfk_pkg::POS_BITS*i
                   +: sixfk_pkg::POS_BITS] = v[sixfk_pkg::POS_BITS-1:0];
      end
      last_v_in = v4_ff[JC-1];
   end

   // output register with one-entry skid
   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      push      = last_v_ff && en;
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = push;
            out_d_in = last_d_ff;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_d_in = last_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= sixfk_pkg::REG_RESET;
         vc_ff     <= '0;
         vf_ff     <= 1'b0;
         v1_ff     <= '0;
         v2_ff     <= '0;
         v3_ff     <= '0;
         v4_ff     <= '0;
         last_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
         if (en) begin
            vc_ff     <= vc_in;
            vf_ff     <= vf_in;
            v1_ff     <= v1_in;
            v2_ff     <= v2_in;
            v3_ff     <= v3_in;
            v4_ff     <= v4_in;
            last_v_ff <= last_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
      if (en) begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         cz_ff     <= cz_in;
         cn_ff     <= cn_in;
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         pc0_ff    <= pc0_in;
         ps0_ff    <= ps0_in;
         pc1_ff    <= pc1_in;
         ps1_ff    <= ps1_in;
         pac_ff    <= pac_in;
         pas_ff    <= pas_in;
         r1_ff     <= r1_in;
         p1_ff     <= p1_in;
         cos1_ff   <= cos1_in;
         sin1_ff   <= sin1_in;
         rn2_ff    <= rn2_in;
         ro2_ff    <= ro2_in;
         t2_ff     <= t2_in;
         p2_ff     <= p2_in;
         cos2_ff   <= cos2_in;
         sin2_ff   <= sin2_in;
         rt3_ff    <= rt3_in;
         rn3_ff    <= rn3_in;
         p3_ff     <= p3_in;
         cos3_ff   <= cos3_in;
         sin3_ff   <= sin3_in;
         r4_ff     <= r4_in;
         p4_ff     <= p4_in;
         cos4_ff   <= cos4_in;
         sin4_ff   <= sin4_in;
         last_d_ff <= last_d_in;
      end
   end

endmodule

>>> src/sixfk_checker.sv
// port-level checks for the six-axis forward kinematics core, bound to the top level
module sixfk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sixfk_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic rot_ok;

   always_comb begin
      logic signed [sixfk_pkg::ROT_BITS-1:0] e;
      rot_ok = 1'b1;
      for (int i = 0; i < sixfk_pkg::ROT_FIELDS; i++) begin
         e = signed'(rsp_tdata[sixfk_pkg::ROT_BITS*i +: sixfk_pkg::ROT_BITS]);
         if ((e > 16'sd16384) || (e < -16'sd16384)) begin
            rot_ok = 1'b0;
         end
      end
   end

   // a stalled result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // input back-pressure only comes from a full output side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // rotation entries stay within plus or minus one
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rot_ok)
      else $error("rotation entry out of range");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind six_axis_forward_kinematics_core sixfk_checker u_sixfk_checker (.*);

>>> verif/six_axis_forward_kinematics_core_test.sv
// testbench for the six-axis forward kinematics core: random and directed poses checked against a local model
module six_axis_forward_kinematics_core_test;

   localparam logic [sixfk_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [sixfk_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   localparam longint ATAN [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
   };
   localparam int TW_COS [6] = '{0, 1, 1, 0, 0, 1};
   localparam int TW_SIN [6] = '{1, 0, 0, 1, -1, 0};

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [sixfk_pkg::REQ_DATA_BITS-1:0]  req_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic [sixfk_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [sixfk_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [sixfk_pkg::REG_BITS-1:0]       csr_data;

   logic [sixfk_pkg::REQ_DATA_BITS-1:0] pending_angles[$];
   logic [sixfk_pkg::RSP_DATA_BITS-1:0] expected_poses[$];
   logic signed [sixfk_pkg::REG_BITS-1:0] link_geometry [sixfk_pkg::REG_COUNT];
   int send_pct, ready_pct;
   int mismatches, cycles;

   six_axis_forward_kinematics_core dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void joint_sin_cos(input logic [15:0] angle, output longint c,
                                         output longint s);
      logic [31:0] phase;
      logic        neg;
      longint      x, y, z, dx, dy;
      phase = {angle, 16'b0};
      neg = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (neg) phase = phase + 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(phase));
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic logic [sixfk_pkg::RSP_DATA_BITS-1:0] predict_pose(
      logic [sixfk_pkg::REQ_DATA_BITS-1:0] angles);
      longint r[3][3], n[3][3], lk[3][3], p[3], t[3];
      longint c, s, a, d, ca, sa, acc;
      logic [sixfk_pkg::RSP_DATA_BITS-1:0] pose;
      for (int i = 0; i < 3; i++) begin
         p[i] = 0;
         for (int j = 0; j < 3; j++) r[i][j] = (i == j) ? 64'sd1073741824 : 0;
      end
      for (int jn = 0; jn < 6; jn++) begin
         joint_sin_cos(angles[jn*16 +: 16], c, s);
         ca = TW_COS[jn];
         sa = TW_SIN[jn];
         a = (jn == 1) ? longint'(link_geometry[sixfk_pkg::REG_UPPER_ARM_LENGTH]) :
             (jn == 2) ? longint'(link_geometry[sixfk_pkg::REG_FOREARM_LENGTH]) : 0;
         d = (jn == 0) ? longint'(link_geometry[sixfk_pkg::REG_SHOULDER_HEIGHT]) :
             (jn == 3) ? longint'(link_geometry[sixfk_pkg::REG_WRIST_ONE_OFFSET]) :
             (jn == 4) ? longint'(link_geometry[sixfk_pkg::REG_WRIST_TWO_OFFSET]) :
             (jn == 5) ? longint'(link_geometry[sixfk_pkg::REG_FLANGE_OFFSET]) : 0;
         lk[0][0] = c; lk[0][1] = -s * ca; lk[0][2] = s * sa;
         lk[1][0] = s; lk[1][1] = c * ca;  lk[1][2] = -c * sa;
         lk[2][0] = 0; lk[2][1] = sa * 64'sd1073741824; lk[2][2] = ca * 64'sd1073741824;
         t[0] = rnd(a * c, 22);
         t[1] = rnd(a * s, 22);
         t[2] = d * 256;
         for (int i = 0; i < 3; i++)
            p[i] = p[i] + rnd(r[i][0] * t[0] + r[i][1] * t[1] + r[i][2] * t[2], 30);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int k = 0; k < 3; k++) acc = acc + r[i][k] * lk[k][j];
               n[i][j] = rnd(acc, 30);
            end
         r = n;
      end
      pose = '0;
      for (int i = 0; i < 9; i++)
         pose[i*16 +: 16] = 16'(clamp(rnd(r[i/3][i%3], 16), -16384, 16384));
      for (int i = 0; i < 3; i++)
         pose[144 + i*18 +: 18] = 18'(clamp(rnd(p[i], 8), -131072, 131071));
      return pose;
   endfunction

   // angle driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_poses.push_back(predict_pose(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_angles.size() > 0 && $urandom_range(99) < send_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_angles.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // pose monitor
   always @(posedge clock) begin
      logic [sixfk_pkg::RSP_DATA_BITS-1:0] want;
      logic bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) < ready_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pose %h", rsp_tdata);
            end else begin
               want = expected_poses.pop_front();
               bad = 1'b0;
               for (int i = 0; i < 9; i++)
                  if (rsp_tdata[i*16 +: 16] !== want[i*16 +: 16]) bad = 1'b1;
               for (int i = 0; i < 3; i++)
                  if (rsp_tdata[144 + i*18 +: 18] !== want[144 + i*18 +: 18]) bad = 1'b1;
               if (rsp_tdata[199:198] !== 2'b00) bad = 1'b1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pose mismatch: expected %h got %h", want, rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_idle();
      wait (pending_angles.size() == 0 && expected_poses.size() == 0 && !req_tvalid);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(logic [sixfk_pkg::CSR_INDEX_BITS-1:0] idx,
                                 logic [sixfk_pkg::REG_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < sixfk_pkg::REG_COUNT) link_geometry[idx] = value;
      csr_valid <= 1'b0;
   endtask

   task automatic set_all_geometry(logic [sixfk_pkg::REG_BITS-1:0] value);
      write_geometry(sixfk_pkg::REG_SHOULDER_HEIGHT, value);
      write_geometry(sixfk_pkg::REG_UPPER_ARM_LENGTH, value);
      write_geometry(sixfk_pkg::REG_FOREARM_LENGTH, value);
      write_geometry(sixfk_pkg::REG_WRIST_ONE_OFFSET, value);
      write_geometry(sixfk_pkg::REG_WRIST_TWO_OFFSET, value);
      write_geometry(sixfk_pkg::REG_FLANGE_OFFSET, value);
   endtask

   task automatic push_uniform(logic [15:0] angle);
      pending_angles.push_back({6{angle}});
   endtask

   function automatic logic [15:0] random_angle();
      unique case ($urandom_range(3))
         0: return 16'($urandom_range(3)) << 14 ^ 16'($urandom_range(7)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [sixfk_pkg::REQ_DATA_BITS-1:0] item;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = sixfk_pkg::REG_SHOULDER_HEIGHT;
      csr_data = '0;
      mismatches = 0;
      cycles = 0;
      send_pct = 100;
      ready_pct = 100;
      for (int i = 0; i < sixfk_pkg::REG_COUNT; i++) link_geometry[i] = sixfk_pkg::REG_RESET[i];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, angle extremes and quadrant edges
      push_uniform(16'h0000);
      push_uniform(16'h7fff);
      push_uniform(16'h8000);
      push_uniform(16'h4000);
      push_uniform(16'hc000);
      push_uniform(16'h3fff);
      push_uniform(16'hbfff);
      push_uniform(16'hffff);
      push_uniform(16'h2000);
      pending_angles.push_back(96'h8000_7fff_0000_ffff_4000_c000);
      wait_idle();

      // largest magnitudes push the position into saturation
      set_all_geometry(18'h1ffff);
      push_uniform(16'h0000);
      push_uniform(16'h4000);
      pending_angles.push_back(96'h0000_0000_0000_0000_0000_0000);
      pending_angles.push_back(96'h1234_c000_4000_8000_0000_4000);
      wait_idle();
      set_all_geometry(18'h20000);
      push_uniform(16'h0000);
      push_uniform(16'h8000);
      push_uniform(16'h4000);
      pending_angles.push_back(96'h0000_c000_4000_8000_0000_4000);
      wait_idle();
      set_all_geometry(18'h00000);
      // writes to unused indexes must be dropped
      write_geometry(CSR_SPARE_LOW, 18'h3ffff);
      write_geometry(CSR_SPARE_HIGH, 18'h15555);
      push_uniform(16'h1000);
      push_uniform(16'h6000);
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph % 4)
            0: begin send_pct = 100; ready_pct = 100; end
            1: begin send_pct = 45;  ready_pct = 100; end
            2: begin send_pct = 100; ready_pct = 45;  end
            default: begin send_pct = 90; ready_pct = 90; end
         endcase
         if (ph == 4) begin
            for (int i = 0; i < sixfk_pkg::REG_COUNT; i++)
               write_geometry(i[2:0], sixfk_pkg::REG_RESET[i]);
         end else begin
            for (int i = 0; i < sixfk_pkg::REG_COUNT; i++) write_geometry(i[2:0], 18'($urandom));
            write_geometry(3'($urandom_range(CSR_SPARE_HIGH, CSR_SPARE_LOW)), 18'($urandom));
         end
         for (int n = 0; n < 100; n++) begin
            for (int j = 0; j < 6; j++) item[j*16 +: 16] = random_angle();
            pending_angles.push_back(item);
         end
         wait_idle();
      end

      if (mismatches == 0 && expected_poses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/sixfk_pkg.sv
src/six_axis_forward_kinematics_core.sv
src/sixfk_checker.sv
verif/six_axis_forward_kinematics_core_test.sv
